### sv/swarq_pkg.sv
`timescale 1ns / 1ps

package swarq_pkg;

    localparam int DATA_COUNT  = 1024;
    localparam int MAX_WINDOW  = 16;
    localparam int MAX_RESULTS = 32;

    localparam int IDX_W  = $clog2(DATA_COUNT);
    localparam int NEXT_W = $clog2(DATA_COUNT + 1);
    localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
    localparam int CNT_W  = $clog2(MAX_RESULTS + 1);

    localparam logic [NEXT_W-1:0] DC_N        = NEXT_W'(DATA_COUNT);
    localparam logic [IDX_W-1:0]  LAST_IDX    = IDX_W'(DATA_COUNT - 1);
    localparam logic [31:0]       LAST_OFFSET = 32'(DATA_COUNT - 1);

    localparam logic [1:0] OP_START    = 2'd0;
    localparam logic [1:0] OP_ACK      = 2'd1;
    localparam logic [1:0] OP_GAP      = 2'd2;
    localparam logic [1:0] OP_HANDOVER = 2'd3;

    localparam logic [1:0] KIND_NEW      = 2'd0;
    localparam logic [1:0] KIND_GAP      = 2'd1;
    localparam logic [1:0] KIND_DUP      = 2'd2;
    localparam logic [1:0] KIND_HANDOVER = 2'd3;

    localparam logic CFG_START_SEQ   = 1'b0;
    localparam logic CFG_WINDOW_SIZE = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACK_CHK,
        ST_WIN_START,
        ST_WIN_CHK,
        ST_DUP,
        ST_RES,
        ST_GAP,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic [31:0] start_seq;
        logic [4:0]  window_size;
    } cfg_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic             wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] seq;
        logic [1:0]  kind;
    } emit_t;

    typedef struct packed {
        logic emit_ok;
        logic flush_done;
        logic pend_valid;
    } obuf_stat_t;

endpackage

### sv/swarq_mark_ram.sv
`timescale 1ns / 1ps

module swarq_mark_ram (
    input  logic                aclk,
    input  swarq_pkg::mem_req_t req,
    output logic                rd_mark
);
    import swarq_pkg::*;

    logic mem [DATA_COUNT];
    logic rd_mark_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            rd_mark_reg <= mem[req.raddr];
        end
    end

    assign rd_mark = rd_mark_reg;

endmodule

### sv/swarq_out_buf.sv
`timescale 1ns / 1ps

module swarq_out_buf (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  swarq_pkg::emit_t      emit,
    input  logic                  flush,
    output swarq_pkg::obuf_stat_t stat,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,
    output logic [1:0]            m_tuser,
    output logic                  m_tlast
);
    import swarq_pkg::*;

    // The newest result is held back one step so that the last one of a
    // request can be tagged once the engine knows nothing more follows.
    logic        pend_valid_reg, pend_valid_next;
    logic [31:0] pend_seq_reg, pend_seq_next;
    logic [1:0]  pend_kind_reg, pend_kind_next;
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_seq_reg, m_seq_next;
    logic [1:0]  m_kind_reg, m_kind_next;
    logic        m_last_reg, m_last_next;
    logic        out_free;

    always_comb begin
        out_free        = !m_valid_reg || m_tready;
        stat.emit_ok    = !pend_valid_reg || out_free;
        stat.flush_done = !pend_valid_reg || out_free;
        stat.pend_valid = pend_valid_reg;

        pend_valid_next = pend_valid_reg;
        pend_seq_next   = pend_seq_reg;
        pend_kind_next  = pend_kind_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_seq_next      = m_seq_reg;
        m_kind_next     = m_kind_reg;
        m_last_next     = m_last_reg;

        if (emit.valid && stat.emit_ok) begin
            if (pend_valid_reg) begin
                m_valid_next = 1'b1;
                m_seq_next   = pend_seq_reg;
                m_kind_next  = pend_kind_reg;
                m_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_seq_next   = emit.seq;
            pend_kind_next  = emit.kind;
        end else if (flush && pend_valid_reg && out_free) begin
            m_valid_next    = 1'b1;
            m_seq_next      = pend_seq_reg;
            m_kind_next     = pend_kind_reg;
            m_last_next     = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        pend_seq_reg  <= pend_seq_next;
        pend_kind_reg <= pend_kind_next;
        m_seq_reg     <= m_seq_next;
        m_kind_reg    <= m_kind_next;
        m_last_reg    <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_seq_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule

### sv/swarq_engine.sv
`timescale 1ns / 1ps

module swarq_engine (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  swarq_pkg::cfg_t       cfg,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [71:0]           s_tdata,
    input  logic [1:0]            s_tuser,
    output swarq_pkg::mem_req_t   mem,
    input  logic                  rd_mark,
    output swarq_pkg::emit_t      emit,
    output logic                  flush,
    input  swarq_pkg::obuf_stat_t stat
);
    import swarq_pkg::*;

    state_t            state_reg, state_next;
    logic [NEXT_W-1:0] next_reg, next_next;
    logic [IDX_W-1:0]  sent_upto_reg, sent_upto_next;
    logic              any_sent_reg, any_sent_next;
    logic              dup_seen_reg, dup_seen_next;
    logic [NEXT_W-1:0] pos_reg, pos_next;
    logic [WIN_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [IDX_W-1:0]  clr_reg, clr_next;
    logic [1:0]        op_reg, op_next;
    logic [31:0]       ack_seq_reg, ack_seq_next;
    logic              gaps_reg, gaps_next;
    logic [31:0]       gap_seq_reg, gap_seq_next;
    logic [1:0]        kind_reg, kind_next;

    logic [WIN_W-1:0]  win;
    logic [31:0]       idx32;
    logic [31:0]       s_idx32;
    logic              in_range;
    logic              cap;
    logic              want;
    logic              proceed;
    logic [WIN_W-1:0]  k_inc;
    logic [NEXT_W-1:0] pos_inc;
    state_t            win_done;

    always_comb begin
        if (32'(cfg.window_size) > MAX_WINDOW) begin
            win = WIN_W'(MAX_WINDOW);
        end else begin
            win = WIN_W'(cfg.window_size);
        end
        idx32    = ack_seq_reg - cfg.start_seq;
        s_idx32  = s_tdata[31:0] - cfg.start_seq;
        in_range = idx32 < 32'(DATA_COUNT);
        cap      = cnt_reg == CNT_W'(MAX_RESULTS);
        k_inc    = k_reg + 1'b1;
        pos_inc  = pos_reg + 1'b1;
        win_done = (op_reg == OP_ACK) ? ST_DUP : ST_FLUSH;

        state_next     = state_reg;
        next_next      = next_reg;
        sent_upto_next = sent_upto_reg;
        any_sent_next  = any_sent_reg;
        dup_seen_next  = dup_seen_reg;
        pos_next       = pos_reg;
        k_next         = k_reg;
        cnt_next       = cnt_reg;
        clr_next       = clr_reg;
        op_next        = op_reg;
        ack_seq_next   = ack_seq_reg;
        gaps_next      = gaps_reg;
        gap_seq_next   = gap_seq_reg;
        kind_next      = kind_reg;

        s_tready  = 1'b0;
        flush     = 1'b0;
        mem       = '0;
        want      = 1'b0;
        emit.seq  = cfg.start_seq + 32'(pos_reg);
        emit.kind = kind_reg;

        case (state_reg)
            ST_WIN_CHK: begin
                want = !rd_mark;
            end
            ST_RES: begin
                want = any_sent_reg && (pos_reg <= NEXT_W'(sent_upto_reg)) && (pos_reg < DC_N);
            end
            ST_GAP: begin
                want = 1'b1;
            end
            default: begin
                want = 1'b0;
            end
        endcase

        emit.valid = want && !cap;
        proceed    = !want || cap || stat.emit_ok;
        if (want && !cap && stat.emit_ok) begin
            cnt_next = cnt_reg + 1'b1;
        end

        case (state_reg)
            ST_CLEAR: begin
                mem.we    = 1'b1;
                mem.waddr = clr_reg;
                mem.wdata = 1'b0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op_next      = s_tuser;
                    ack_seq_next = s_tdata[31:0];
                    gaps_next    = s_tdata[32];
                    gap_seq_next = s_tdata[64:33];
                    cnt_next     = '0;
                    case (s_tuser)
                        OP_START: begin
                            kind_next  = KIND_NEW;
                            state_next = ST_WIN_START;
                        end
                        OP_ACK: begin
                            kind_next = KIND_NEW;
                            if (s_idx32 < 32'(DATA_COUNT)) begin
                                mem.re    = 1'b1;
                                mem.raddr = s_idx32[IDX_W-1:0];
                            end
                            state_next = ST_ACK_CHK;
                        end
                        OP_GAP: begin
                            kind_next  = KIND_GAP;
                            state_next = ST_GAP;
                        end
                        default: begin
                            kind_next  = KIND_HANDOVER;
                            pos_next   = next_reg;
                            state_next = ST_RES;
                        end
                    endcase
                end
            end
            ST_ACK_CHK: begin
                if (in_range && (idx32 >= 32'(next_reg)) && rd_mark) begin
                    next_next  = NEXT_W'(idx32) + 1'b1;
                    state_next = ST_WIN_START;
                end else begin
                    if (in_range && (idx32 < 32'(next_reg))) begin
                        dup_seen_next = 1'b1;
                    end
                    state_next = ST_DUP;
                end
            end
            ST_WIN_START: begin
                pos_next = next_reg;
                k_next   = '0;
                if ((win != '0) && (next_reg < DC_N)) begin
                    mem.re     = 1'b1;
                    mem.raddr  = next_reg[IDX_W-1:0];
                    state_next = ST_WIN_CHK;
                end else begin
                    state_next = win_done;
                end
            end
            ST_WIN_CHK: begin
                if (proceed) begin
                    if (!rd_mark) begin
                        mem.we    = 1'b1;
                        mem.waddr = pos_reg[IDX_W-1:0];
                        mem.wdata = 1'b1;
                        if (!any_sent_reg || (NEXT_W'(sent_upto_reg) <= pos_reg)) begin
                            sent_upto_next = pos_reg[IDX_W-1:0];
                            any_sent_next  = 1'b1;
                        end
                    end
                    k_next   = k_inc;
                    pos_next = pos_inc;
                    if ((k_inc < win) && (pos_inc < DC_N)) begin
                        mem.re    = 1'b1;
                        mem.raddr = pos_inc[IDX_W-1:0];
                    end else begin
                        state_next = win_done;
                    end
                end
            end
            ST_DUP: begin
                if (!gaps_reg && dup_seen_reg
                        && (ack_seq_reg != cfg.start_seq + LAST_OFFSET)) begin
                    dup_seen_next = 1'b0;
                    kind_next     = KIND_DUP;
                    pos_next      = next_reg;
                    state_next    = ST_RES;
                end else begin
                    state_next = ST_FLUSH;
                end
            end
            ST_RES: begin
                if (!want) begin
                    state_next = ST_FLUSH;
                end else if (proceed) begin
                    pos_next = pos_inc;
                end
            end
            ST_GAP: begin
                emit.seq = gap_seq_reg;
                if (proceed) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                flush = 1'b1;
                if (stat.flush_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            next_reg      <= '0;
            sent_upto_reg <= '0;
            any_sent_reg  <= 1'b0;
            dup_seen_reg  <= 1'b0;
            clr_reg       <= '0;
            cnt_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            next_reg      <= next_next;
            sent_upto_reg <= sent_upto_next;
            any_sent_reg  <= any_sent_next;
            dup_seen_reg  <= dup_seen_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
        end
        pos_reg     <= pos_next;
        k_reg       <= k_next;
        op_reg      <= op_next;
        ack_seq_reg <= ack_seq_next;
        gaps_reg    <= gaps_next;
        gap_seq_reg <= gap_seq_next;
        kind_reg    <= kind_next;
    end

endmodule

### sv/sliding_window_arq_sender_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// s_        in         s_tvalid/s_tready   tdata: ack_seq, gaps_follow, gap_seq; tuser: opcode
// m_        out        m_tvalid/m_tready   tdata: send_seq; tuser: send_kind; tlast: last_of_run
// cfg_      in         cfg_valid/cfg_ready cfg_index selects start_seq or window_size
//
// After reset the sent-mark memory is cleared one entry a cycle, all 1024 entries, before the
// first request is taken; configuration writes are accepted throughout.
// A start walks the window from the next unacked offset. An ack reads its mark, walks the window
// when it moves the pointer, and may then resend the outstanding offsets after a duplicate.
// A gap entry issues one result, a handover resends the outstanding offsets, one offset a cycle unless stalled.
// A stalled result channel holds the walk; up to two results wait, one held back, one at the output.

module sliding_window_arq_sender_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [31:0] ack_seq, [32] gaps_follow, [64:33] gap_seq
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] send_seq
    output logic [1:0]  m_tuser,   // [1:0] send_kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    import swarq_pkg::*;

    logic [31:0] start_seq_reg;
    logic [4:0]  window_size_reg;
    cfg_t        cfg;
    mem_req_t    mem;
    logic        rd_mark;
    emit_t       emit;
    logic        flush;
    obuf_stat_t  stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_seq_reg   <= '0;
            window_size_reg <= 5'd4;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_START_SEQ: begin
                    start_seq_reg <= cfg_data;
                end
                CFG_WINDOW_SIZE: begin
                    window_size_reg <= cfg_data[4:0];
                end
                default: begin
                    start_seq_reg <= start_seq_reg;
                end
            endcase
        end
    end

    assign cfg.start_seq   = start_seq_reg;
    assign cfg.window_size = window_size_reg;

    swarq_mark_ram u_ram (
        .aclk    (aclk),
        .req     (mem),
        .rd_mark (rd_mark)
    );

    swarq_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .mem      (mem),
        .rd_mark  (rd_mark),
        .emit     (emit),
        .flush    (flush),
        .stat     (stat)
    );

    swarq_out_buf u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .emit     (emit),
        .flush    (flush),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !stat.pend_valid)
        else $error("Request taken while a result is still held back.");

    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("Second request taken before the first finished.");

    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem.we && mem.re) |-> (mem.waddr != mem.raddr))
        else $error("Mark memory read and written at the same entry.");

    a_flush_no_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        flush |-> !emit.valid)
        else $error("Result issued while the request is being closed.");

endmodule

### tb/sv/arq_send_checker.sv
`timescale 1ns / 1ps

module arq_send_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,   // [31:0] ack_seq, [32] gaps_follow, [64:33] gap_seq
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [31:0] send_seq
    input  logic [1:0]  m_tuser,   // [1:0] send_kind
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    output int          mismatch_count,
    output int          pending_sends
);

    import swarq_pkg::*;

    typedef struct packed {
        logic [31:0] seq;
        logic [1:0]  kind;
        logic        last;
    } send_rec_t;

    send_rec_t   expected_sends [$];
    send_rec_t   want;
    int          miss_cnt;
    int          run_len;
    int          clr_i;

    logic        sent_mark [DATA_COUNT];
    logic [31:0] acked_ofs;
    logic [31:0] sent_hi_ofs;
    logic        any_sent_q;
    logic        dup_pending;
    logic [31:0] cfg_start;
    logic [4:0]  cfg_window;

    initial begin
        miss_cnt = 0;
    end

    task automatic add_send(input logic [31:0] seq, input logic [1:0] kind);
        send_rec_t rec;
        if (run_len < MAX_RESULTS) begin
            rec.seq  = seq;
            rec.kind = kind;
            rec.last = 1'b0;
            expected_sends.push_back(rec);
            run_len++;
        end
    endtask

    task automatic fill_window();
        logic [31:0] base;
        logic [31:0] ofs;
        int          w;
        int          k;
        base = acked_ofs + 32'd1;
        w    = (cfg_window > MAX_WINDOW) ? MAX_WINDOW : int'(cfg_window);
        for (k = 0; k < w; k++) begin
            ofs = base + 32'(k);
            if (ofs >= DATA_COUNT) break;
            if (!sent_mark[ofs[IDX_W-1:0]]) begin
                sent_mark[ofs[IDX_W-1:0]] = 1'b1;
                add_send(cfg_start + ofs, KIND_NEW);
                if (!any_sent_q || sent_hi_ofs <= ofs) begin
                    sent_hi_ofs = ofs;
                    any_sent_q  = 1'b1;
                end
            end
        end
    endtask

    task automatic resend_outstanding(input logic [1:0] kind);
        logic [31:0] ofs;
        if (any_sent_q) begin
            for (ofs = acked_ofs + 32'd1; ofs <= sent_hi_ofs && ofs < DATA_COUNT; ofs++)
                add_send(cfg_start + ofs, kind);
        end
    endtask

    task automatic predict_sends(input logic [1:0] op, input logic [31:0] ack_v,
                                 input logic gaps_follow, input logic [31:0] gap_v);
        logic [31:0] ofs;
        logic [31:0] nxt;
        send_rec_t   tail;
        ofs     = ack_v - cfg_start;
        nxt     = acked_ofs + 32'd1;
        run_len = 0;
        case (op)
            OP_START: begin
                fill_window();
            end
            OP_ACK: begin
                if (ofs < DATA_COUNT) begin
                    if (ofs >= nxt && sent_mark[ofs[IDX_W-1:0]]) begin
                        acked_ofs = ofs;
                        fill_window();
                    end else if (ofs < nxt) begin
                        dup_pending = 1'b1;
                    end
                end
                // The final sequence never triggers a duplicate resend and keeps it pending.
                if (!gaps_follow && dup_pending && ack_v != cfg_start + LAST_OFFSET) begin
                    resend_outstanding(KIND_DUP);
                    dup_pending = 1'b0;
                end
            end
            OP_GAP: begin
                add_send(gap_v, KIND_GAP);
            end
            default: begin
                resend_outstanding(KIND_HANDOVER);
            end
        endcase
        if (run_len > 0) begin
            tail      = expected_sends.pop_back();
            tail.last = 1'b1;
            expected_sends.push_back(tail);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (clr_i = 0; clr_i < DATA_COUNT; clr_i++)
                sent_mark[clr_i] = 1'b0;
            acked_ofs   = 32'hFFFF_FFFF;
            sent_hi_ofs = 32'd0;
            any_sent_q  = 1'b0;
            dup_pending = 1'b0;
            cfg_start   = 32'd0;
            cfg_window  = 5'd4;
            expected_sends.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_sends.size() == 0) begin
                    if (miss_cnt < 10)
                        $display("Unexpected send request: seq %h kind %0d last %0b",
                                 m_tdata, m_tuser, m_tlast);
                    miss_cnt++;
                end else begin
                    want = expected_sends.pop_front();
                    if (m_tdata !== want.seq || m_tuser !== want.kind ||
                        m_tlast !== want.last) begin
                        if (miss_cnt < 10)
                            $display("Send mismatch: expected seq %h kind %0d last %0b, %s",
                                     want.seq, want.kind, want.last,
                                     $sformatf("got seq %h kind %0d last %0b",
                                               m_tdata, m_tuser, m_tlast));
                        miss_cnt++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_START_SEQ)
                    cfg_start = cfg_data;
                else
                    cfg_window = cfg_data[4:0];
            end
            if (s_tvalid && s_tready)
                predict_sends(s_tuser, s_tdata[31:0], s_tdata[32], s_tdata[64:33]);
        end
        mismatch_count <= miss_cnt;
        pending_sends  <= expected_sends.size();
    end

endmodule

### tb/sv/tb_sliding_window_arq_sender_core.sv
`timescale 1ns / 1ps

module tb_sliding_window_arq_sender_core;

    import swarq_pkg::*;

    localparam int LIMIT_CYCLES   = 2_500_000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int RX_HOLD_CYCLES = 600;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [31:0] cfg_data;

    int          mismatch_count;
    int          pending_sends;
    int          cycles = 0;
    int          rx_hold_req = 0;
    logic        tx_quiet = 1'b0;
    logic        rx_quiet = 1'b0;

    logic [31:0] cur_start = 32'd0;
    logic [4:0]  cur_win = 5'd4;
    int          tb_acked = -1;
    int          tb_sent_hi = -1;

    sliding_window_arq_sender_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    arq_send_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_sends  (pending_sends)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        while (cycles < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : rx_side
        int   hold_done;
        int   r;
        int   dur;
        logic ready_v;
        hold_done = 0;
        forever begin
            if (rx_hold_req != hold_done) begin
                hold_done++;
                ready_v = 1'b0;
                dur     = RX_HOLD_CYCLES;
            end else if (rx_quiet) begin
                ready_v = 1'b1;
                dur     = 1;
            end else begin
                r       = $urandom_range(0, 99);
                ready_v = (r < 60);
                if (r < 60)
                    dur = $urandom_range(1, 8);
                else if (r < 92)
                    dur = $urandom_range(1, 3);
                else
                    dur = $urandom_range(10, 40);
            end
            m_tready <= ready_v;
            repeat (dur) @(posedge aclk);
        end
    end

    function automatic void track(input logic [1:0] op, input logic [31:0] ack_v);
        logic [31:0] ofs;
        logic        moved;
        int          w;
        int          top;
        w     = (cur_win > MAX_WINDOW) ? MAX_WINDOW : int'(cur_win);
        ofs   = ack_v - cur_start;
        moved = 1'b0;
        if (op == OP_ACK && ofs < DATA_COUNT && int'(ofs) > tb_acked &&
            int'(ofs) <= tb_sent_hi) begin
            tb_acked = int'(ofs);
            moved    = 1'b1;
        end
        if ((op == OP_START || moved) && w > 0) begin
            top = tb_acked + w;
            if (top > DATA_COUNT - 1) top = DATA_COUNT - 1;
            if (top > tb_sent_hi) tb_sent_hi = top;
        end
    endfunction

    task automatic issue(input logic [1:0] op, input logic [31:0] ack_v,
                         input logic gaps_follow, input logic [31:0] gap_v);
        int idle;
        int r;
        if (tx_quiet) begin
            idle = 0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 50)
                idle = 0;
            else if (r < 85)
                idle = $urandom_range(1, 3);
            else if (r < 97)
                idle = $urandom_range(4, 10);
            else
                idle = $urandom_range(20, 60);
        end
        cfg_valid <= 1'b0;
        if (idle > 0) begin
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, gap_v, gaps_follow, ack_v};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        track(op, ack_v);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == CFG_START_SEQ)
            cur_start = val;
        else
            cur_win = val[4:0];
    endtask

    task automatic settle();
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b0;
        @(posedge aclk);
        while (pending_sends != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic random_request(input logic push_end);
        int          r;
        logic [1:0]  op;
        logic [31:0] a;
        logic [31:0] g;
        logic        gf;
        r  = $urandom_range(0, 99);
        op = OP_ACK;
        a  = $urandom;
        g  = $urandom;
        gf = ($urandom_range(0, 3) == 0);
        if (push_end && r < 90) begin
            if (tb_sent_hi > tb_acked)
                a = cur_start + 32'(tb_sent_hi);
            else
                op = OP_START;
        end else if (r < 40) begin
            if (tb_sent_hi > tb_acked)
                a = cur_start + 32'($urandom_range(tb_acked + 1, tb_sent_hi));
            else
                op = OP_START;
        end else if (r < 55) begin
            a  = cur_start + ((tb_acked >= 0) ? 32'($urandom_range(0, tb_acked)) : 32'd0);
            gf = $urandom_range(0, 1);
        end else if (r < 67) begin
            op = OP_GAP;
            if (r < 62) g = cur_start + 32'($urandom_range(0, DATA_COUNT - 1));
        end else if (r < 75) begin
            op = OP_HANDOVER;
        end else if (r < 87) begin
            op = OP_START;
        end else if (r < 93) begin
            a = cur_start + LAST_OFFSET;
        end
        issue(op, a, gf, g);
    endtask

    initial begin : stimulus
        int ph;
        int n;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_START;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_START_SEQ;
        cfg_data  <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        issue(OP_HANDOVER, $urandom, 1'b0, $urandom);
        issue(OP_ACK, cur_start, 1'b0, $urandom);
        issue(OP_GAP, $urandom, 1'b1, 32'hFFFF_FFFF);
        issue(OP_GAP, $urandom, 1'b0, 32'h0000_0000);
        issue(OP_START, $urandom, 1'b1, $urandom);
        issue(OP_START, $urandom, 1'b0, $urandom);
        issue(OP_ACK, cur_start + 32'd2, 1'b0, $urandom);
        issue(OP_ACK, cur_start + 32'd1, 1'b1, $urandom);
        issue(OP_GAP, $urandom, 1'b0, cur_start + 32'd3);
        issue(OP_ACK, cur_start + 32'd1, 1'b0, $urandom);
        issue(OP_HANDOVER, $urandom, 1'b1, $urandom);
        issue(OP_ACK, cur_start + DATA_COUNT, 1'b0, $urandom);
        issue(OP_ACK, cur_start - 32'd1, 1'b1, $urandom);
        issue(OP_ACK, cur_start, 1'b1, $urandom);
        issue(OP_ACK, cur_start + LAST_OFFSET, 1'b0, $urandom);
        issue(OP_ACK, cur_start + 32'd40, 1'b0, $urandom);
        issue(OP_ACK, cur_start + 32'd6, 1'b0, $urandom);
        settle();
        write_reg(CFG_WINDOW_SIZE, {27'($urandom), 5'd0});
        issue(OP_START, $urandom, 1'b0, $urandom);
        issue(OP_ACK, cur_start + 32'd8, 1'b0, $urandom);
        settle();
        write_reg(CFG_WINDOW_SIZE, {27'($urandom), 5'd31});
        issue(OP_START, $urandom, 1'b0, $urandom);
        settle();
        write_reg(CFG_START_SEQ, 32'hFFFF_FFFF);
        issue(OP_ACK, cur_start + 32'd24, 1'b0, $urandom);
        issue(OP_HANDOVER, $urandom, 1'b0, $urandom);

        for (ph = 0; ph < 8; ph++) begin
            settle();
            n = 40;
            case (ph)
                0: begin
                    write_reg(CFG_START_SEQ, $urandom);
                    write_reg(CFG_WINDOW_SIZE, {27'($urandom), 5'd1});
                end
                1: begin
                    write_reg(CFG_START_SEQ, 32'd0);
                    write_reg(CFG_WINDOW_SIZE, {27'($urandom), 5'd16});
                end
                2: begin
                    write_reg(CFG_START_SEQ, 32'hFFFF_FFFF);
                    write_reg(CFG_WINDOW_SIZE, {27'($urandom), 5'($urandom_range(2, 8))});
                end
                3: begin
                    write_reg(CFG_START_SEQ, $urandom);
                    write_reg(CFG_WINDOW_SIZE, {27'($urandom), 5'd0});
                    n = 20;
                end
                4: begin
                    write_reg(CFG_WINDOW_SIZE, {27'($urandom), 5'($urandom_range(17, 31))});
                end
                5: begin
                    write_reg(CFG_WINDOW_SIZE, {27'($urandom), 5'd16});
                    n = 90;
                end
                6: begin
                    write_reg(CFG_START_SEQ, 32'hFFFF_FFF0);
                end
                default: begin
                    write_reg(CFG_START_SEQ, $urandom);
                    write_reg(CFG_WINDOW_SIZE, {27'($urandom), 5'd31});
                end
            endcase
            tx_quiet <= (ph == 1 || ph == 2);
            rx_quiet <= (ph == 1);
            // The receiver holds off long enough for the block to back up into its input.
            if (ph == 2) rx_hold_req <= rx_hold_req + 1;
            repeat (n) random_request(ph == 5);
        end

        settle();
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
